FILE: rtl/serial_command_queue_with_retry_top_defines.svh
// assertion macros for the serial command queue with retry
// used by serial_command_queue_with_retry_top, expects clk_i and rst_ni in scope
`ifndef SERIAL_COMMAND_QUEUE_WITH_RETRY_TOP_DEFINES_SVH
`define SERIAL_COMMAND_QUEUE_WITH_RETRY_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define SCQR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("scqr assertion failed");
`define SCQR_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) pre |=> post) \
    else $error("scqr assertion failed");
`else
`define SCQR_ASSERT(lbl, prop)
`define SCQR_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

FILE: rtl/scqr_pkg.sv
// types and constants of the serial command queue with retry
// no dependencies
`default_nettype none
package scqr_pkg;
  localparam int unsigned QUEUE_DEPTH_DEF = 16;
  localparam int unsigned FRAME_BYTES     = 5;
  localparam int unsigned REPLY_LEN       = 5;
  localparam int unsigned CFG_IDX_W       = 3;
  localparam int unsigned CFG_DATA_W      = 14;
  localparam int unsigned LINK_DEPTH      = 2;

  localparam logic [7:0] FRAME_START  = 8'h02;
  localparam logic [7:0] REPLY_START  = 8'h82;
  localparam logic [7:0] STATUS_REPLY = 8'hc6;
  localparam logic [7:0] POWER_ODD    = 8'he0;

  localparam logic [9:0]  TX_DELAY_RST    = 10'd350;
  localparam logic [11:0] POLL_PERIOD_RST = 12'd1100;
  localparam logic [9:0]  REPLY_TO_RST    = 10'd500;
  localparam logic [2:0]  RETRY_LIM_RST   = 3'd3;
  localparam logic [13:0] OFFLINE_TO_RST  = 14'd10000;
  localparam logic [13:0] READY_DLY_RST   = 14'd10000;
  localparam logic [7:0]  STATUS_CODE_RST = 8'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TX_DELAY    = 3'd0,
    CFG_POLL_PERIOD = 3'd1,
    CFG_REPLY_TO    = 3'd2,
    CFG_RETRY_LIM   = 3'd3,
    CFG_OFFLINE_TO  = 3'd4,
    CFG_READY_DLY   = 3'd5,
    CFG_STATUS_CODE = 3'd6
  } cfg_idx_e;

  typedef enum logic [1:0] {
    EVT_TICK    = 2'd0,
    EVT_ENQUEUE = 2'd1,
    EVT_TX_RDY  = 2'd2,
    EVT_RX_BYTE = 2'd3
  } evt_kind_e;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] command_code;
    logic       has_data;
    logic [7:0] command_data;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       power_on;
    logic       device_ready;
    logic       offline;
    logic       awaiting_reply;
  } result_t;

  typedef struct packed {
    evt_kind_e  kind;
    logic [7:0] code;
    logic       has_data;
    logic [7:0] data;
    logic [7:0] rx_byte;
  } event_t;
endpackage
`default_nettype wire

FILE: rtl/scqr_fifo.sv
// small register fifo used on both sides of the engine
// no dependencies
`default_nettype none
module scqr_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       push_i,
  input  wire logic [WIDTH-1:0]           data_i,
  input  wire logic                       pop_i,
  output logic [WIDTH-1:0]                data_o,
  output logic                            full_o,
  output logic                            empty_o,
  output logic [$clog2(DEPTH+1)-1:0]      count_o
);
  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH+1);

  logic [DEPTH-1:0][WIDTH-1:0] mem_q;
  logic [PW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;
  logic do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == PW'(DEPTH-1)) ? '0 : wr_q + 1'b1;
      if (do_pop)  rd_q <= (rd_q == PW'(DEPTH-1)) ? '0 : rd_q + 1'b1;
      if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= data_i;
  end
endmodule
`default_nettype wire

FILE: rtl/scqr_front.sv
// front end: accepts input transactions, buffers and classifies them
// depends on scqr_pkg and scqr_fifo
`default_nettype none
module scqr_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push,
  output logic                   full,
  input  wire scqr_pkg::in_item_t item_i,
  output logic                   evt_valid_o,
  output scqr_pkg::event_t       evt_o,
  input  wire logic              evt_pop_i
);
  import scqr_pkg::*;

  in_item_t head;
  logic     empty;
  logic [$clog2(LINK_DEPTH+1)-1:0] cnt;

  scqr_fifo #(.WIDTH($bits(in_item_t)), .DEPTH(LINK_DEPTH)) u_fifo (
    .clk_i, .rst_ni,
    .push_i(push), .data_i(item_i), .pop_i(evt_pop_i),
    .data_o(head), .full_o(full), .empty_o(empty), .count_o(cnt)
  );

  assign evt_valid_o = !empty && (cnt != '0);

  always_comb begin
    evt_o          = '0;
    evt_o.kind     = evt_kind_e'(head.cmd);
    evt_o.code     = head.command_code;
    evt_o.has_data = head.has_data;
    evt_o.data     = head.command_data;
    evt_o.rx_byte  = head.rx_byte;
  end
endmodule
`default_nettype wire

FILE: rtl/scqr_back.sv
// back end: frame ring, transmit, reply hunt, timers and configuration
// depends on scqr_pkg
`default_nettype none
module scqr_back #(
  parameter int unsigned QUEUE_DEPTH = scqr_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_valid_i,
  input  wire logic [scqr_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [scqr_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                            evt_valid_i,
  input  wire scqr_pkg::event_t                evt_i,
  output logic                                 evt_pop_o,
  input  wire logic                            out_full_i,
  output logic                                 out_push_o,
  output scqr_pkg::result_t                    result_o
);
  import scqr_pkg::*;

  localparam int unsigned IW = $clog2(QUEUE_DEPTH);
  typedef logic [IW-1:0] slot_t;

  function automatic slot_t nxt(slot_t s);
    return (s == IW'(QUEUE_DEPTH-1)) ? '0 : s + 1'b1;
  endfunction

  // configuration
  logic [9:0]  tx_delay_q, reply_to_q;
  logic [11:0] poll_q;
  logic [2:0]  retry_lim_q;
  logic [13:0] offline_q, ready_dly_q;
  logic [7:0]  status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_delay_q  <= TX_DELAY_RST;
      poll_q      <= POLL_PERIOD_RST;
      reply_to_q  <= REPLY_TO_RST;
      retry_lim_q <= RETRY_LIM_RST;
      offline_q   <= OFFLINE_TO_RST;
      ready_dly_q <= READY_DLY_RST;
      status_q    <= STATUS_CODE_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_TX_DELAY:    tx_delay_q  <= cfg_data_i[9:0];
        CFG_POLL_PERIOD: poll_q      <= cfg_data_i[11:0];
        CFG_REPLY_TO:    reply_to_q  <= cfg_data_i[9:0];
        CFG_RETRY_LIM:   retry_lim_q <= cfg_data_i[2:0];
        CFG_OFFLINE_TO:  offline_q   <= cfg_data_i;
        CFG_READY_DLY:   ready_dly_q <= cfg_data_i;
        CFG_STATUS_CODE: status_q    <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // frame ring: code, data flag and byte 3 per slot, byte 4 is derived
  logic [QUEUE_DEPTH-1:0]       vld_q;
  logic [QUEUE_DEPTH-1:0][7:0]  code_q, b3_q;
  logic [QUEUE_DEPTH-1:0]       hd_q;

  slot_t ws_q, ss_q;
  logic [2:0] bi_q, ri_q;
  logic [REPLY_LEN-1:0][7:0] rb_q;
  logic [7:0] lc_q;
  logic f_rx_q, f_done_q, f_tx_q, f_pw_q, f_pst_q, f_rdy_q, f_off_q, en_tx_q, en_rx_q;
  logic [10:0] swc_q, rwc_q;
  logic [12:0] pc_q;
  logic [14:0] rc_q, sc_q;
  logic [2:0]  rty_q;

  slot_t ws_d, ss_d;
  logic [2:0] bi_d, ri_d;
  logic [REPLY_LEN-1:0][7:0] rb_d;
  logic [7:0] lc_d;
  logic f_rx_d, f_done_d, f_tx_d, f_pw_d, f_pst_d, f_rdy_d, f_off_d, en_tx_d, en_rx_d;
  logic [10:0] swc_d, rwc_d;
  logic [12:0] pc_d;
  logic [14:0] rc_d, sc_d;
  logic [2:0]  rty_d;
  logic wr_en, clr_all, hd_w, tx_v;
  slot_t wr_slot;
  logic [7:0] code_w, b3_w, tx_b;

  logic fire;
  assign fire       = evt_valid_i && !out_full_i;
  assign evt_pop_o  = fire;
  assign out_push_o = fire;

  // fields of the slot being sent
  logic       cur_v, cur_hd;
  logic [7:0] cur_code, cur_b3;
  logic [2:0] cur_len;
  assign cur_v    = vld_q[ss_q];
  assign cur_hd   = cur_v && hd_q[ss_q];
  assign cur_code = cur_v ? code_q[ss_q] : 8'h00;
  assign cur_b3   = cur_v ? b3_q[ss_q] : 8'h00;
  assign cur_len  = cur_hd ? 3'd5 : 3'd4;

  always_comb begin
    ws_d = ws_q; ss_d = ss_q; bi_d = bi_q; ri_d = ri_q; rb_d = rb_q; lc_d = lc_q;
    f_rx_d = f_rx_q; f_done_d = f_done_q; f_tx_d = f_tx_q; f_pw_d = f_pw_q;
    f_pst_d = f_pst_q; f_rdy_d = f_rdy_q; f_off_d = f_off_q;
    en_tx_d = en_tx_q; en_rx_d = en_rx_q;
    swc_d = swc_q; rwc_d = rwc_q; pc_d = pc_q; rc_d = rc_q; sc_d = sc_q; rty_d = rty_q;
    wr_en = 1'b0; clr_all = 1'b0; wr_slot = ws_q; code_w = 8'h00; hd_w = 1'b0;
    b3_w = 8'h00; tx_v = 1'b0; tx_b = 8'h00;

    unique case (evt_i.kind)
      EVT_ENQUEUE: begin
        wr_en = 1'b1; wr_slot = ws_d; code_w = evt_i.code; hd_w = evt_i.has_data;
        b3_w = evt_i.has_data ? evt_i.data : FRAME_START + evt_i.code;
        lc_d = evt_i.code;
        if (nxt(ws_d) != ss_d) ws_d = nxt(ws_d);
        if (!f_rx_d && !f_done_d) f_tx_d = 1'b1;
      end
      EVT_TX_RDY: begin
        if (en_tx_q) begin
          if (bi_q >= cur_len) begin
            rb_d = '0; f_rx_d = 1'b1; bi_d = '0; ri_d = '0; rwc_d = '0;
            en_tx_d = 1'b0; en_rx_d = 1'b1;
          end else begin
            tx_v = 1'b1;
            unique case (bi_q)
              3'd0:    tx_b = cur_v ? FRAME_START : 8'h00;
              3'd1:    tx_b = cur_code;
              3'd2:    tx_b = {7'd0, cur_hd};
              3'd3:    tx_b = cur_b3;
              default: tx_b = FRAME_START + cur_code + 8'h01 + cur_b3;
            endcase
            bi_d = bi_q + 3'd1;
          end
        end
      end
      EVT_RX_BYTE: begin
        if (en_rx_q) begin
          if (ri_q < 3'(REPLY_LEN)) rb_d[ri_q] = evt_i.rx_byte;
          if (f_rx_q && rb_d[0] == REPLY_START) begin
            ri_d = ri_q + 3'd1;
            if (ri_d >= 3'(REPLY_LEN)) begin
              f_done_d = 1'b1; f_rx_d = 1'b0; ri_d = '0; rty_d = '0; en_rx_d = 1'b0;
            end
          end
        end
      end
      default: begin
        // millisecond tick
        if (f_tx_d) begin
          if (swc_d > {1'b0, tx_delay_q}) begin
            f_tx_d = 1'b0; ri_d = '0; swc_d = '0; en_tx_d = 1'b1;
          end else begin
            swc_d = swc_d + 11'd1;
          end
          pc_d = '0;
        end else begin
          if (pc_d > {1'b0, poll_q}) begin
            pc_d = '0;
            wr_en = 1'b1; wr_slot = ws_d; code_w = status_q; hd_w = 1'b0;
            b3_w = FRAME_START + status_q; lc_d = status_q;
            if (nxt(ws_d) != ss_d) ws_d = nxt(ws_d);
            if (!f_rx_d && !f_done_d) f_tx_d = 1'b1;
          end else begin
            pc_d = pc_d + 13'd1;
          end
          if (!f_rdy_d && f_pst_d) begin
            if (rc_d > {1'b0, ready_dly_q}) begin
              f_rdy_d = 1'b1; rc_d = '0;
            end else begin
              rc_d = rc_d + 15'd1;
            end
          end else begin
            rc_d = '0;
          end
          swc_d = '0;
        end

        if (sc_d > {1'b0, offline_q}) begin
          // offline reinit: empty ring, then queue a status read in slot zero
          clr_all = 1'b1;
          f_rx_d = 1'b0; f_done_d = 1'b0; f_pw_d = 1'b0;
          f_pst_d = 1'b0; f_rdy_d = 1'b0; bi_d = '0; ss_d = '0; rwc_d = '0;
          wr_en = 1'b1; wr_slot = '0; code_w = status_q; hd_w = 1'b0;
          b3_w = FRAME_START + status_q; lc_d = status_q;
          ws_d = nxt('0);
          f_tx_d = 1'b1;
          f_off_d = 1'b1; sc_d = '0;
        end else begin
          sc_d = sc_d + 15'd1;
        end

        if (!f_rx_d && f_done_d) begin
          f_off_d = 1'b0; sc_d = '0;
          if (rb_d[1] == STATUS_REPLY && lc_d == status_q) begin
            if (rb_d[3][7]) begin
              f_pw_d = 1'b1;
              if (!f_pst_d && rb_d[3] != POWER_ODD) begin
                f_pst_d = 1'b1; f_rdy_d = 1'b0;
              end
            end else begin
              f_pw_d = 1'b0; f_pst_d = 1'b0; f_rdy_d = 1'b0;
            end
          end
          ss_d = nxt(ss_d);
          if (ss_d != ws_d) f_tx_d = 1'b1;
          f_done_d = 1'b0;
        end else if (f_rx_d) begin
          rwc_d = rwc_d + 11'd1;
          if (rwc_d > {1'b0, reply_to_q}) begin
            rwc_d = '0;
            rty_d = rty_d + 3'd1;
            if (rty_d >= retry_lim_q) begin
              rty_d = '0;
              if (ss_d == ws_d) begin
                f_rx_d = 1'b0; f_done_d = 1'b0;
              end else begin
                ss_d = nxt(ss_d);
                if (ss_d != ws_d) begin
                  f_tx_d = 1'b1; f_rx_d = 1'b0;
                end
              end
            end else begin
              f_tx_d = 1'b1; f_rx_d = 1'b0;
            end
          end
        end
      end
    endcase
  end

  always_comb begin
    result_o.tx_valid       = tx_v;
    result_o.tx_byte        = tx_b;
    result_o.power_on       = f_pw_d;
    result_o.device_ready   = f_rdy_d;
    result_o.offline        = f_off_d;
    result_o.awaiting_reply = f_rx_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      ws_q <= '0; ss_q <= '0; bi_q <= '0; ri_q <= '0; rb_q <= '0; lc_q <= '0;
      f_rx_q <= 1'b0; f_done_q <= 1'b0; f_tx_q <= 1'b0; f_pw_q <= 1'b0;
      f_pst_q <= 1'b0; f_rdy_q <= 1'b0; f_off_q <= 1'b0;
      en_tx_q <= 1'b0; en_rx_q <= 1'b0;
      swc_q <= '0; rwc_q <= '0; pc_q <= '0; rc_q <= '0; sc_q <= '0; rty_q <= '0;
    end else if (fire) begin
      if (clr_all) vld_q <= '0;
      if (wr_en) vld_q[wr_slot] <= 1'b1;
      ws_q <= ws_d; ss_q <= ss_d; bi_q <= bi_d; ri_q <= ri_d; rb_q <= rb_d; lc_q <= lc_d;
      f_rx_q <= f_rx_d; f_done_q <= f_done_d; f_tx_q <= f_tx_d; f_pw_q <= f_pw_d;
      f_pst_q <= f_pst_d; f_rdy_q <= f_rdy_d; f_off_q <= f_off_d;
      en_tx_q <= en_tx_d; en_rx_q <= en_rx_d;
      swc_q <= swc_d; rwc_q <= rwc_d; pc_q <= pc_d; rc_q <= rc_d; sc_q <= sc_d;
      rty_q <= rty_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && wr_en) begin
      code_q[wr_slot] <= code_w;
      hd_q[wr_slot]   <= hd_w;
      b3_q[wr_slot]   <= b3_w;
    end
  end
endmodule
`default_nettype wire

FILE: rtl/serial_command_queue_with_retry_top.sv
// serial command queue with retry, top level
// depends on scqr_pkg, scqr_fifo, scqr_front, scqr_back and the defines header
`default_nettype none
`include "serial_command_queue_with_retry_top_defines.svh"
// usage
//  input channel: an event transaction (tick, enqueue, transmitter ready,
//  received byte) is taken when push is high and full is low
//  result channel: one result per event, oldest on result_o while empty is
//  low, taken when pop is high and empty is low
//  config channel: cfg_valid_i/cfg_ready_o with register index and data;
//  ready is always high, write only while the block is idle
//  path: an event waits in the input queue, the engine works on the queue head
//  and writes its result into the result queue, which drives result_o
//  throughput: one event per cycle while the result queue has room; the event
//  engine updates the ring pointers, counters and one frame slot per event
//  a two-entry queue separates front and engine, another separates engine
//  and result port, so a stalled reader backs up into full after 4 events
//  reset: all flags, counters and slot valid bits clear at once, registers
//  take their defaults; no clearing pass is needed
module serial_command_queue_with_retry_top #(
  parameter int unsigned QUEUE_DEPTH = scqr_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            push,
  output logic                                 full,
  input  wire scqr_pkg::in_item_t              item_i,
  output logic                                 empty,
  input  wire logic                            pop,
  output scqr_pkg::result_t                    result_o,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [scqr_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [scqr_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import scqr_pkg::*;

  logic    evt_valid, evt_pop, out_full, out_push;
  event_t  evt;
  result_t res;
  logic [$clog2(LINK_DEPTH+1)-1:0] out_cnt;

  // config writes are always accepted
  assign cfg_ready_o = 1'b1;

  // front: buffers and classifies events
  scqr_front u_front (
    .clk_i, .rst_ni, .push, .full, .item_i,
    .evt_valid_o(evt_valid), .evt_o(evt), .evt_pop_i(evt_pop)
  );

  // back: runs one event per cycle when the result queue has room
  scqr_back #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
    .clk_i, .rst_ni,
    .cfg_valid_i(cfg_valid_i && cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .evt_valid_i(evt_valid), .evt_i(evt), .evt_pop_o(evt_pop),
    .out_full_i(out_full), .out_push_o(out_push), .result_o(res)
  );

  // result queue
  scqr_fifo #(.WIDTH($bits(result_t)), .DEPTH(LINK_DEPTH)) u_out (
    .clk_i, .rst_ni,
    .push_i(out_push), .data_i(res), .pop_i(pop),
    .data_o(result_o), .full_o(out_full), .empty_o(empty), .count_o(out_cnt)
  );

  // engine must drain an event whenever the result queue has room
  `SCQR_ASSERT(a_evt_drain, evt_valid && !out_full |-> evt_pop)
  // last result taken with nothing new coming leaves the port empty
  `SCQR_ASSERT_NEXT(a_out_empty, pop && !empty && out_cnt == 1 && !out_push, empty)
endmodule
`default_nettype wire

FILE: tb/serial_command_queue_with_retry_top_tb.sv
// testbench for serial_command_queue_with_retry_top: directed and random event streams,
// results checked against an in-bench model of the frame ring, retry and status logic
// depends on scqr_pkg and the rtl of the block
`default_nettype none
module serial_command_queue_with_retry_top_tb;
  import scqr_pkg::*;

  localparam int unsigned QD = QUEUE_DEPTH_DEF;
  localparam int unsigned IDLE_LIMIT = 2000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic full;
  in_item_t item_i = '0;
  logic empty;
  logic pop = 1'b0;
  result_t result_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  serial_command_queue_with_retry_top dut (
    .clk_i, .rst_ni, .push, .full, .item_i, .empty, .pop, .result_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ---------------- model of the block ----------------
  int unsigned tx_delay_q, poll_period_q, reply_to_q, retry_lim_q;
  int unsigned offline_to_q, ready_dly_q;
  logic [7:0] status_code_q;

  logic [7:0] ring [QD*FRAME_BYTES];
  int unsigned wr_slot, snd_slot, byte_idx, rep_idx;
  logic [7:0] rep_buf [REPLY_LEN];
  logic [7:0] last_code;
  bit awaiting, reply_done, tx_pending, power, power_stable, dev_ready, offline_f;
  bit tx_en, rx_en;
  int unsigned send_wait, poll_cnt, ready_cnt, silence_cnt, reply_wait, retry_cnt;

  result_t expected_results [$];
  int unsigned error_count = 0;
  bit no_idle = 1'b0;

  function automatic int unsigned slot_after(int unsigned s);
    return (s + 1 >= QD) ? 0 : s + 1;
  endfunction

  function automatic void model_reset();
    tx_delay_q = TX_DELAY_RST; poll_period_q = POLL_PERIOD_RST;
    reply_to_q = REPLY_TO_RST; retry_lim_q = RETRY_LIM_RST;
    offline_to_q = OFFLINE_TO_RST; ready_dly_q = READY_DLY_RST;
    status_code_q = STATUS_CODE_RST;
    foreach (ring[i]) ring[i] = '0;
    foreach (rep_buf[i]) rep_buf[i] = '0;
    wr_slot = 0; snd_slot = 0; byte_idx = 0; rep_idx = 0; last_code = '0;
    {awaiting, reply_done, tx_pending, power, power_stable, dev_ready, offline_f} = '0;
    tx_en = 0; rx_en = 0;
    send_wait = 0; poll_cnt = 0; ready_cnt = 0; silence_cnt = 0;
    reply_wait = 0; retry_cnt = 0;
  endfunction

  function automatic void store_frame(logic [7:0] code, bit hd, logic [7:0] data);
    int unsigned base;
    base = wr_slot * FRAME_BYTES;
    last_code = code;
    ring[base] = FRAME_START;
    ring[base+1] = code;
    if (hd) begin
      ring[base+2] = 8'd1;
      ring[base+3] = data;
      ring[base+4] = FRAME_START + code + 8'd1 + data;
    end else begin
      ring[base+2] = 8'd0;
      ring[base+3] = FRAME_START + code;
    end
    wr_slot = slot_after(wr_slot);
    // ring full: step back so the newest frame gets overwritten
    if (wr_slot == snd_slot) wr_slot = (wr_slot == 0) ? QD - 1 : wr_slot - 1;
    if (!awaiting && !reply_done) tx_pending = 1;
  endfunction

  function automatic void judge_status();
    if (rep_buf[1] != STATUS_REPLY || last_code != status_code_q) return;
    if (rep_buf[3][7]) begin
      power = 1;
      if (!power_stable && rep_buf[3] != POWER_ODD) begin
        power_stable = 1;
        dev_ready = 0;
      end
    end else begin
      power = 0; power_stable = 0; dev_ready = 0;
    end
  endfunction

  function automatic void model_tick();
    if (tx_pending) begin
      if (send_wait > tx_delay_q) begin
        tx_pending = 0; rep_idx = 0; send_wait = 0; tx_en = 1;
      end else send_wait++;
      poll_cnt = 0;
    end else begin
      if (poll_cnt > poll_period_q) begin
        poll_cnt = 0;
        store_frame(status_code_q, 0, 8'd0);
      end else poll_cnt++;
      if (!dev_ready && power_stable) begin
        if (ready_cnt > ready_dly_q) begin
          dev_ready = 1; ready_cnt = 0;
        end else ready_cnt++;
      end else ready_cnt = 0;
      send_wait = 0;
    end
    // long silence: wipe the ring and restart with a status read
    if (silence_cnt > offline_to_q) begin
      foreach (ring[i]) ring[i] = '0;
      {awaiting, reply_done, tx_pending, power, power_stable, dev_ready} = '0;
      byte_idx = 0; wr_slot = 0; snd_slot = 0; reply_wait = 0;
      store_frame(status_code_q, 0, 8'd0);
      offline_f = 1;
      silence_cnt = 0;
    end else silence_cnt++;
    if (!awaiting && reply_done) begin
      offline_f = 0; silence_cnt = 0;
      judge_status();
      snd_slot = slot_after(snd_slot);
      if (snd_slot != wr_slot) tx_pending = 1;
      reply_done = 0;
    end else if (awaiting) begin
      reply_wait++;
      if (reply_wait > reply_to_q) begin
        reply_wait = 0;
        retry_cnt++;
        if (retry_cnt >= retry_lim_q) begin
          retry_cnt = 0;
          if (snd_slot == wr_slot) begin
            awaiting = 0; reply_done = 0;
          end else begin
            snd_slot = slot_after(snd_slot);
            if (snd_slot != wr_slot) begin
              tx_pending = 1; awaiting = 0;
            end
          end
        end else begin
          tx_pending = 1; awaiting = 0;
        end
      end
    end
  endfunction

  function automatic result_t predict_event(in_item_t it);
    result_t r;
    int unsigned base;
    r = '0;
    case (evt_kind_e'(it.cmd))
      EVT_TICK: model_tick();
      EVT_ENQUEUE: store_frame(it.command_code, it.has_data, it.command_data);
      EVT_TX_RDY: begin
        base = snd_slot * FRAME_BYTES;
        if (tx_en) begin
          if (byte_idx >= ring[base+2] + 4 || byte_idx >= FRAME_BYTES) begin
            // end of frame: nothing sent, start hunting for the reply
            foreach (rep_buf[i]) rep_buf[i] = '0;
            awaiting = 1; byte_idx = 0; rep_idx = 0; reply_wait = 0;
            tx_en = 0; rx_en = 1;
          end else begin
            r.tx_valid = 1'b1;
            r.tx_byte = ring[base+byte_idx];
            byte_idx++;
          end
        end
      end
      default: begin
        if (rx_en) begin
          rep_buf[rep_idx % REPLY_LEN] = it.rx_byte;
          if (awaiting && rep_buf[0] == REPLY_START) begin
            rep_idx++;
            if (rep_idx >= REPLY_LEN) begin
              reply_done = 1; awaiting = 0; rep_idx = 0; retry_cnt = 0; rx_en = 0;
            end
          end
        end
      end
    endcase
    r.power_on = power;
    r.device_ready = dev_ready;
    r.offline = offline_f;
    r.awaiting_reply = awaiting;
    return r;
  endfunction

  // ---------------- driving ----------------
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_event(in_item_t it);
    int unsigned gap;
    push <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (full);
    expected_results.push_back(predict_event(it));
    gap = pick_gap();
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_kind(evt_kind_e k, logic [7:0] code, bit hd, logic [7:0] data,
                           logic [7:0] rxb);
    in_item_t it;
    it.cmd = k; it.command_code = code; it.has_data = hd;
    it.command_data = data; it.rx_byte = rxb;
    send_event(it);
  endtask

  // wait until every transaction has come back, then let the engine settle
  task automatic drain();
    push <= 1'b0;
    @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // valid stays high across back-to-back writes, write_all drops it at the end
  task automatic write_reg(cfg_idx_e idx, int unsigned value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value[CFG_DATA_W-1:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_TX_DELAY:    tx_delay_q = value & 32'h3ff;
      CFG_POLL_PERIOD: poll_period_q = value & 32'hfff;
      CFG_REPLY_TO:    reply_to_q = value & 32'h3ff;
      CFG_RETRY_LIM:   retry_lim_q = value & 32'h7;
      CFG_OFFLINE_TO:  offline_to_q = value & 32'h3fff;
      CFG_READY_DLY:   ready_dly_q = value & 32'h3fff;
      default:         status_code_q = value[7:0];
    endcase
  endtask

  task automatic write_all(int unsigned txd, int unsigned poll, int unsigned rto,
                           int unsigned rlim, int unsigned offt, int unsigned rdy,
                           int unsigned sc);
    write_reg(CFG_TX_DELAY, txd);
    write_reg(CFG_POLL_PERIOD, poll);
    write_reg(CFG_REPLY_TO, rto);
    write_reg(CFG_RETRY_LIM, rlim);
    write_reg(CFG_OFFLINE_TO, offt);
    write_reg(CFG_READY_DLY, rdy);
    write_reg(CFG_STATUS_CODE, sc);
    cfg_valid_i <= 1'b0;
  endtask

  // any event with fully random fields
  task automatic send_noise();
    in_item_t it;
    it = in_item_t'({$urandom, $urandom});
    send_event(it);
  endtask

  // one command exchange: enqueue, wait out the delay, send the frame, answer it
  task automatic send_exchange();
    logic [7:0] b3;
    int unsigned r;
    r = $urandom_range(0, 3);
    b3 = (r == 0) ? 8'h80 : (r == 1) ? POWER_ODD : (r == 2) ? 8'h00 : 8'($urandom);
    if ($urandom_range(0, 3) != 0) send_kind(EVT_ENQUEUE, status_code_q, 0, 8'h00, 8'h00);
    else send_kind(EVT_ENQUEUE, 8'($urandom), 1'($urandom), 8'($urandom), 8'h00);
    repeat (tx_delay_q + 2) send_kind(EVT_TICK, 8'($urandom), 0, 8'h00, 8'h00);
    repeat ($urandom_range(5, 7)) send_kind(EVT_TX_RDY, 8'h00, 0, 8'h00, 8'($urandom));
    if ($urandom_range(0, 4) == 0) send_kind(EVT_RX_BYTE, 0, 0, 0, 8'($urandom));
    send_kind(EVT_RX_BYTE, 0, 0, 0, REPLY_START);
    send_kind(EVT_RX_BYTE, 0, 0, 0, ($urandom_range(0, 4) != 0) ? STATUS_REPLY : 8'($urandom));
    send_kind(EVT_RX_BYTE, 0, 0, 0, 8'($urandom));
    send_kind(EVT_RX_BYTE, 0, 0, 0, b3);
    if ($urandom_range(0, 5) != 0) send_kind(EVT_RX_BYTE, 0, 0, 0, 8'($urandom));
    repeat ($urandom_range(1, 3)) send_kind(EVT_TICK, 0, 0, 0, 0);
  endtask

  task automatic random_phase(int unsigned n_items);
    for (int unsigned sent = 0; sent < n_items; ) begin
      if ($urandom_range(0, 3) != 0) begin
        send_exchange();
        sent += 18;
      end else begin
        repeat ($urandom_range(1, 6)) send_noise();
        sent += 4;
      end
    end
  endtask

  // ---------------- tests ----------------
  task automatic test_directed();
    write_all(0, 4095, 2, 1, 16383, 0, 8'h55);
    send_kind(EVT_ENQUEUE, 8'h55, 0, 8'hff, 8'h00);
    send_kind(EVT_TX_RDY, 0, 0, 0, 0);      // sending still disabled
    send_kind(EVT_RX_BYTE, 0, 0, 0, 8'h82); // reception disabled
    repeat (2) send_kind(EVT_TICK, 0, 0, 0, 0);
    repeat (5) send_kind(EVT_TX_RDY, 0, 0, 0, 0);
    send_kind(EVT_RX_BYTE, 0, 0, 0, 8'h00); // hunting for the start byte
    send_kind(EVT_RX_BYTE, 0, 0, 0, REPLY_START);
    send_kind(EVT_RX_BYTE, 0, 0, 0, STATUS_REPLY);
    send_kind(EVT_RX_BYTE, 0, 0, 0, 8'h00);
    send_kind(EVT_RX_BYTE, 0, 0, 0, 8'hff);
    send_kind(EVT_RX_BYTE, 0, 0, 0, 8'hff);
    send_kind(EVT_TICK, 0, 0, 0, 0);
    send_kind(EVT_TICK, 0, 0, 0, 0);        // ready delay of zero starts counting
    send_kind(EVT_ENQUEUE, 8'hff, 1, 8'hff, 8'h00);
    send_kind(EVT_ENQUEUE, 8'h00, 1, 8'h00, 8'hff);
    repeat (2) send_kind(EVT_TICK, 0, 0, 0, 0);
    repeat (6) send_kind(EVT_TX_RDY, 0, 0, 0, 0);
    drain();
  endtask

  task automatic test_timeouts();
    // retry limit zero and drop with an empty ring, no replies at all
    write_all(0, 3, 1, 0, 40, 2, 0);
    repeat (120) begin
      if ($urandom_range(0, 2) == 0) send_kind(EVT_TX_RDY, 0, 0, 0, 0);
      else send_kind(EVT_TICK, 0, 0, 0, 0);
    end
    drain();
    write_all(1, 0, 0, 7, 0, 16383, 8'hff);
    repeat (60) send_noise();
    drain();
  endtask

  task automatic test_ring_full();
    write_all(1023, 4095, 1023, 7, 16383, 16383, 8'haa);
    repeat (24) send_kind(EVT_ENQUEUE, 8'($urandom), 1'($urandom), 8'($urandom), 0);
    repeat (40) send_kind(EVT_TICK, 0, 0, 0, 0);
    drain();
  endtask

  task automatic test_random();
    for (int p = 0; p < 6; p++) begin
      no_idle = (p == 2);
      write_all($urandom_range(0, 4), $urandom_range(0, 60), $urandom_range(0, 20),
                $urandom_range(0, 7), ($urandom_range(0, 3) == 0) ? $urandom_range(0, 5)
                : $urandom_range(50, 400), $urandom_range(0, 30),
                ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(0, 255));
      random_phase(115);
      // sender holds off until everything has come back, then continues
      drain();
      random_phase(115);
      drain();
    end
    no_idle = 1'b0;
  endtask

  // ---------------- result checking ----------------
  initial begin
    result_t exp_r;
    int unsigned stall;
    stall = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && pop && !empty) begin
        if (expected_results.size() == 0) begin
          $error("result transaction with no expectation waiting");
          error_count++;
        end else begin
          exp_r = expected_results.pop_front();
          if (result_o.tx_valid !== exp_r.tx_valid) begin
            $error("tx_valid exp %0h got %0h", exp_r.tx_valid, result_o.tx_valid);
            error_count++;
          end
          if (result_o.tx_byte !== exp_r.tx_byte) begin
            $error("tx_byte exp %0h got %0h", exp_r.tx_byte, result_o.tx_byte);
            error_count++;
          end
          if (result_o.power_on !== exp_r.power_on) begin
            $error("power_on exp %0h got %0h", exp_r.power_on, result_o.power_on);
            error_count++;
          end
          if (result_o.device_ready !== exp_r.device_ready) begin
            $error("device_ready exp %0h got %0h", exp_r.device_ready,
                   result_o.device_ready);
            error_count++;
          end
          if (result_o.offline !== exp_r.offline) begin
            $error("offline exp %0h got %0h", exp_r.offline, result_o.offline);
            error_count++;
          end
          if (result_o.awaiting_reply !== exp_r.awaiting_reply) begin
            $error("awaiting_reply exp %0h got %0h", exp_r.awaiting_reply,
                   result_o.awaiting_reply);
            error_count++;
          end
        end
      end
      // reader stalls: mostly short, sometimes long, none while no_idle
      if (stall != 0) begin
        pop <= 1'b0;
        stall--;
      end else begin
        pop <= 1'b1;
        stall = pick_gap();
      end
    end
  end

  // watchdog: too many cycles without any transaction
  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((push && !full) || (pop && !empty) || (cfg_valid_i && cfg_ready_o))
        idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    model_reset();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_timeouts();
    test_ring_full();
    test_random();
    drain();
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
`default_nettype wire

FILE: filelist.f
+incdir+rtl
rtl/scqr_pkg.sv
rtl/scqr_fifo.sv
rtl/scqr_front.sv
rtl/scqr_back.sv
rtl/serial_command_queue_with_retry_top.sv
tb/serial_command_queue_with_retry_top_tb.sv
